// ----- design/crc_pkg.sv -----
package crc_pkg;

   localparam int MAX_SIDE = 512;
   localparam int SIDE_BITS = $clog2(MAX_SIDE);
   localparam int SIZE_BITS = SIDE_BITS + 1;
   localparam int ADDR_BITS = 2 * SIDE_BITS;
   localparam int CANVAS_DEPTH = MAX_SIDE * MAX_SIDE;

   localparam int OP_BITS = 2;
   localparam int COORD_BITS = 20;
   localparam int RADIUS_BITS = 19;
   localparam int CHAR_BITS = 8;
   localparam int POS_BITS = 9;
   localparam int STATUS_BITS = 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 10;

   localparam int FRAC_BITS = 8;
   localparam int ONE_Q8 = 1 << FRAC_BITS;
   localparam int DIST_BITS = COORD_BITS + 1;
   localparam int MAG_BITS = COORD_BITS;
   localparam int SQ_BITS = 2 * MAG_BITS;
   localparam int SQ_STEPS = MAG_BITS;
   localparam int SQ_CNT_BITS = $clog2(SQ_STEPS);

   localparam int CSR_BG_RESET = 32;

   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DRAW = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_RADIUS = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OUT_OF_RANGE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BACKGROUND = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SQ_LOAD,
      S_SQ_RUN,
      S_ROW,
      S_PIXEL,
      S_READ,
      S_READ_WAIT,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      SQ_CX,
      SQ_CY,
      SQ_R,
      SQ_RI
   } sq_sel_type;

endpackage

// ----- design/crc_if.sv -----
interface crc_req_if;
   import crc_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [OP_BITS-1:0]            operation;
   logic signed [COORD_BITS-1:0]  center_x;
   logic signed [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0]        radius;
   logic                          filled;
   logic [CHAR_BITS-1:0]          ink;
   logic [POS_BITS-1:0]           row;
   logic [POS_BITS-1:0]           column;
   modport source (output valid, operation, center_x, center_y, radius, filled, ink,
                   row, column, input ready);
   modport sink (input valid, operation, center_x, center_y, radius, filled, ink,
                 row, column, output ready);
endinterface

interface crc_rsp_if;
   import crc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CHAR_BITS-1:0]    pixel;
   logic [STATUS_BITS-1:0]  status;
   modport source (output valid, pixel, status, input ready);
   modport sink (input valid, pixel, status, output ready);
endinterface

interface crc_csr_if;
   import crc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/circle_raster_canvas_core.sv -----
// Character canvas of 512 x 512 entries in a single-port memory, one word per
// item on each side. A clear writes the background character to every entry,
// one entry per cycle. A draw first squares the centre coordinates, the
// radius and the radius less one on a shared shift-add squarer, each square
// loaded in S_SQ_LOAD and built in S_SQ_RUN, then walks the rows and columns
// in use at one pixel per cycle, keeping the squared distance up to date by
// adding the difference of consecutive squares; each row begins with a setup
// step in S_ROW. A read goes through the registered memory port in S_READ and
// S_READ_WAIT; a draw with zero radius, an out-of-range read or an unused
// operation goes straight to the result. The block takes one item at a time
// and holds off new words until its result word has been taken. Configuration
// writes are always taken.
module circle_raster_canvas_core (
   input logic         clock,
   input logic         reset,
   crc_req_if.sink     req_chan,
   crc_rsp_if.source   rsp_chan,
   crc_csr_if.sink     csr_chan
);
   import crc_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [CHAR_BITS-1:0] bg_ff;

   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_BITS-1:0]       radius_ff, radius_in;
   logic                         filled_ff, filled_in;
   logic [CHAR_BITS-1:0]         ink_ff, ink_in;
   logic [POS_BITS-1:0]          row_ff, row_in, col_ff, col_in;

   logic [CHAR_BITS-1:0]   pixel_ff, pixel_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   sq_sel_type             sq_sel_ff, sq_sel_in;
   logic [MAG_BITS-1:0]    mag_ff, mag_in;
   logic [SQ_BITS-1:0]     mcand_ff, mcand_in;
   logic [SQ_BITS-1:0]     acc_ff, acc_in;
   logic [SQ_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [SQ_BITS-1:0] cx2_ff, cx2_in, dy2_ff, dy2_in, r2_ff, r2_in, ri2_ff, ri2_in;
   logic [SQ_BITS-1:0] d2_ff, d2_in;
   logic signed [DIST_BITS-1:0] dx_ff, dx_in, dy_ff, dy_in;

   logic [SIZE_BITS-1:0] w_eff, h_eff;
   logic                 req_fire, rsp_fire;
   logic                 read_in_range, last_col, last_row, clear_done, sq_last;
   logic                 size_zero, inner_neg, pix_write;

   logic signed [DIST_BITS-1:0] op_val, op_abs;
   logic [SQ_BITS-1:0]          acc_sum;

   logic                        step_row;
   logic [SQ_BITS-1:0]          step_sq;
   logic signed [DIST_BITS-1:0] step_d;
   logic signed [SQ_BITS:0]     d_ext, step_sum;
   logic [SQ_BITS-1:0]          step_new;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [CHAR_BITS-1:0] ram_wdata, ram_rdata;

   crc_ram #(
      .WIDTH (CHAR_BITS),
      .DEPTH (CANVAS_DEPTH)
   ) u_canvas (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // configuration
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIZE_BITS'(MAX_SIDE);
         height_ff <= SIZE_BITS'(MAX_SIDE);
         bg_ff <= CHAR_BITS'(CSR_BG_RESET);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WIDTH: width_ff <= csr_chan.data[SIZE_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_chan.data[SIZE_BITS-1:0];
            CSR_BACKGROUND: bg_ff <= csr_chan.data[CHAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshakes and conditions
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = (state_ff == S_RESP);
   assign rsp_chan.pixel = pixel_ff;
   assign rsp_chan.status = status_ff;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign w_eff = (width_ff > SIZE_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE) : width_ff;
   assign h_eff = (height_ff > SIZE_BITS'(MAX_SIDE)) ? SIZE_BITS'(MAX_SIDE) : height_ff;
   assign size_zero = (w_eff == '0) || (h_eff == '0);
   assign read_in_range = ({1'b0, req_chan.row} < h_eff) && ({1'b0, req_chan.column} < w_eff);
   assign last_col = ({1'b0, col_ff} == (w_eff - SIZE_BITS'(1)));
   assign last_row = ({1'b0, row_ff} == (h_eff - SIZE_BITS'(1)));
   assign clear_done = (&row_ff) && (&col_ff);
   assign sq_last = (cnt_ff == SQ_CNT_BITS'(SQ_STEPS - 1));

   // shared squarer operand
   always_comb begin
      case (sq_sel_ff)
         SQ_CX: op_val = DIST_BITS'(cx_ff);
         SQ_CY: op_val = DIST_BITS'(cy_ff);
         SQ_R: op_val = DIST_BITS'({2'b00, radius_ff});
         SQ_RI: op_val = DIST_BITS'({2'b00, radius_ff}) - DIST_BITS'(ONE_Q8);
         default: op_val = '0;
      endcase
   end

   assign op_abs = op_val[DIST_BITS-1] ? -op_val : op_val;
   assign acc_sum = acc_ff + (mag_ff[0] ? mcand_ff : '0);

   // next square from the previous one: (d - 1)^2 = d^2 - 2d + 1, d in Q8, squares in Q16
   assign step_row = last_col;
   assign step_sq = step_row ? dy2_ff : d2_ff;
   assign step_d = step_row ? dy_ff : dx_ff;
   assign d_ext = {{(SQ_BITS + 1 - DIST_BITS){step_d[DIST_BITS-1]}}, step_d};
   assign step_sum = $signed({1'b0, step_sq}) - (d_ext <<< (FRAC_BITS + 1))
                     + $signed((SQ_BITS + 1)'(ONE_Q8 * ONE_Q8));
   assign step_new = step_sum[SQ_BITS-1:0];

   assign inner_neg = (radius_ff < RADIUS_BITS'(ONE_Q8));
   assign pix_write = (d2_ff <= r2_ff) && (filled_ff || inner_neg || (d2_ff > ri2_ff));

   // memory port
   always_comb begin
      ram_addr = {row_ff, col_ff};
      ram_we = 1'b0;
      ram_wdata = ink_ff;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_wdata = bg_ff;
         end
         S_PIXEL: ram_we = pix_write;
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.operation)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_DRAW: state_in = (req_chan.radius == '0) ? S_RESP : S_SQ_LOAD;
                  OP_READ: state_in = read_in_range ? S_READ : S_RESP;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_CLEAR: if (clear_done) state_in = S_RESP;
         S_SQ_LOAD: state_in = S_SQ_RUN;
         S_SQ_RUN: begin
            if (sq_last) begin
               if (sq_sel_ff == SQ_RI) begin
                  state_in = size_zero ? S_RESP : S_ROW;
               end else begin
                  state_in = S_SQ_LOAD;
               end
            end
         end
         S_ROW: state_in = S_PIXEL;
         S_PIXEL: begin
            if (last_col) begin
               state_in = last_row ? S_RESP : S_ROW;
            end
         end
         S_READ: state_in = S_READ_WAIT;
         S_READ_WAIT: state_in = S_RESP;
         S_RESP: if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      radius_in = radius_ff;
      filled_in = filled_ff;
      ink_in = ink_ff;
      row_in = row_ff;
      col_in = col_ff;
      pixel_in = pixel_ff;
      status_in = status_ff;
      sq_sel_in = sq_sel_ff;
      mag_in = mag_ff;
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      cx2_in = cx2_ff;
      dy2_in = dy2_ff;
      r2_in = r2_ff;
      ri2_in = ri2_ff;
      d2_in = d2_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cx_in = req_chan.center_x;
               cy_in = req_chan.center_y;
               radius_in = req_chan.radius;
               filled_in = req_chan.filled;
               ink_in = req_chan.ink;
               dy_in = DIST_BITS'(req_chan.center_y);
               sq_sel_in = SQ_CX;
               pixel_in = '0;
               status_in = STATUS_OK;
               row_in = '0;
               col_in = '0;
               case (req_chan.operation)
                  OP_DRAW: begin
                     if (req_chan.radius == '0) status_in = STATUS_BAD_RADIUS;
                  end
                  OP_READ: begin
                     row_in = req_chan.row;
                     col_in = req_chan.column;
                     if (!read_in_range) status_in = STATUS_OUT_OF_RANGE;
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: {row_in, col_in} = {row_ff, col_ff} + ADDR_BITS'(1);
         S_SQ_LOAD: begin
            mag_in = op_abs[MAG_BITS-1:0];
            mcand_in = SQ_BITS'(op_abs[MAG_BITS-1:0]);
            acc_in = '0;
            cnt_in = '0;
         end
         S_SQ_RUN: begin
            acc_in = acc_sum;
            mag_in = mag_ff >> 1;
            mcand_in = mcand_ff << 1;
            cnt_in = cnt_ff + SQ_CNT_BITS'(1);
            if (sq_last) begin
               case (sq_sel_ff)
                  SQ_CX: cx2_in = acc_sum;
                  SQ_CY: dy2_in = acc_sum;
                  SQ_R: r2_in = acc_sum;
                  SQ_RI: ri2_in = acc_sum;
                  default: ;
               endcase
               sq_sel_in = sq_sel_type'(sq_sel_ff + 2'd1);
            end
         end
         S_ROW: begin
            d2_in = cx2_ff + dy2_ff;
            dx_in = DIST_BITS'(cx_ff);
            col_in = '0;
         end
         S_PIXEL: begin
            if (last_col) begin
               dy2_in = step_new;
               dy_in = dy_ff - DIST_BITS'(ONE_Q8);
               row_in = row_ff + POS_BITS'(1);
            end else begin
               d2_in = step_new;
               dx_in = dx_ff - DIST_BITS'(ONE_Q8);
               col_in = col_ff + POS_BITS'(1);
            end
         end
         S_READ_WAIT: pixel_in = ram_rdata;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      radius_ff <= radius_in;
      filled_ff <= filled_in;
      ink_ff <= ink_in;
      row_ff <= row_in;
      col_ff <= col_in;
      pixel_ff <= pixel_in;
      status_ff <= status_in;
      sq_sel_ff <= sq_sel_in;
      mag_ff <= mag_in;
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      cx2_ff <= cx2_in;
      dy2_ff <= dy2_in;
      r2_ff <= r2_in;
      ri2_ff <= ri2_in;
      d2_ff <= d2_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
   end

endmodule

// ----- design/crc_ram.sv -----
module crc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
